>>> rtl/ffaa_pkg.sv
// shared constants, types and helpers of the first-fit allocator
package ffaa_pkg;

    localparam int MAX_EXTENTS     = 64;
    localparam int MAX_RECORDS     = 64;
    localparam int HEADER_BYTES    = 8;
    localparam int MIN_BLOCK_BYTES = 8;
    localparam int POOL_MAX        = 65536;

    localparam int POS_W   = 17;
    localparam int TOT_W   = 18;
    localparam int ALIGN_W = 13;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 7;
    localparam int EIDX_W  = 6;
    localparam int RIDX_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NULL  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_BYTES = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } t_ext;

    typedef struct packed {
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   total;
        logic [ALIGN_W-1:0] offset;
    } t_rec;

    typedef struct packed {
        logic shift;
        logic load;
    } t_chain_ctl;

    function automatic logic [ALIGN_W-1:0] norm_align(input logic [ALIGN_W-1:0] v);
        logic [ALIGN_W-1:0] p;
        p = ALIGN_W'(1);
        for (int i = 0; i < ALIGN_W; i++) begin
            if (v[i]) begin
                p = ALIGN_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/ffaa_if.sv
// request and response channel interfaces
interface ffaa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [ffaa_pkg::POS_W-1:0]    request_bytes;
    logic [ffaa_pkg::ALIGN_W-1:0]  align_bytes;
    logic [ffaa_pkg::ADDR_W-1:0]   free_address;
    modport source (output valid, opcode, request_bytes, align_bytes, free_address,
                    input ready);
    modport sink   (input valid, opcode, request_bytes, align_bytes, free_address,
                    output ready);
endinterface

interface ffaa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffaa_pkg::STAT_W-1:0]   status;
    logic [ffaa_pkg::ADDR_W-1:0]   granted_address;
    logic [ffaa_pkg::POS_W-1:0]    used_total;
    logic [ffaa_pkg::CNT_W-1:0]    live_count;
    modport source (output valid, status, granted_address, used_total, live_count,
                    input ready);
    modport sink   (input valid, status, granted_address, used_total, live_count,
                    output ready);
endinterface

>>> rtl/ffaa_ext_cell.sv
// one cell of the free extent chain
module ffaa_ext_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  logic           i_load,
    input  ffaa_pkg::t_ext i_load_val,
    input  ffaa_pkg::t_ext i_next,
    output ffaa_pkg::t_ext o_q
);
    ffaa_pkg::t_ext r_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_load_val;
        end else if (i_shift) begin
            r_q <= i_next;
        end
    end

    assign o_q = r_q;
endmodule

>>> rtl/ffaa_ext_chain.sv
// row of extent cells rotating toward the head
module ffaa_ext_chain (
    input  logic                i_clk,
    input  ffaa_pkg::t_chain_ctl i_ctl,
    input  ffaa_pkg::t_ext      i_load_val,
    input  ffaa_pkg::t_ext      i_feed,
    output ffaa_pkg::t_ext      o_head
);
    ffaa_pkg::t_ext w_q [ffaa_pkg::MAX_EXTENTS];

    for (genvar g = 0; g < ffaa_pkg::MAX_EXTENTS; g++) begin : g_cell
        ffaa_pkg::t_ext w_next;
        if (g == ffaa_pkg::MAX_EXTENTS - 1) begin : g_tail
            assign w_next = i_feed;
        end else begin : g_mid
            assign w_next = w_q[g+1];
        end
        ffaa_ext_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_ctl.shift),
            .i_load     ((g == 0) ? i_ctl.load : 1'b0),
            .i_load_val (i_load_val),
            .i_next     (w_next),
            .o_q        (w_q[g])
        );
    end

    assign o_head = w_q[0];
endmodule

>>> rtl/ffaa_rec_mem.sv
// live allocation record store
module ffaa_rec_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ffaa_pkg::RIDX_W-1:0] i_waddr,
    input  ffaa_pkg::t_rec              i_wdata,
    input  logic [ffaa_pkg::RIDX_W-1:0] i_raddr,
    output ffaa_pkg::t_rec              o_rdata
);
    ffaa_pkg::t_rec r_mem [ffaa_pkg::MAX_RECORDS];
    ffaa_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/first_fit_aligned_allocator_unit.sv
// first-fit aligned allocator top level
// null free and allocate with full record table: no scan or rotation, the result is registered from the done state
// allocate: one rotation of the extent chain
// free: record scan (one record read per cycle), then one rotation of the extent chain on a hit, none on a miss
// one request at a time; a new request is taken only after the previous result is registered
// synchronous reset and pool_bytes write leave one free extent, no live records
module first_fit_aligned_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ffaa_req_if.sink                    i_req,
    ffaa_rsp_if.source                  o_rsp,
    input  logic                        i_cfg_wr_en,
    input  logic [0:0]                  i_cfg_index,
    input  logic [ffaa_pkg::ADDR_W-1:0] i_cfg_data
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RSCAN = 2'd1;
    localparam logic [1:0] S_PASS  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [1:0] M_NORM  = 2'd0;
    localparam logic [1:0] M_LEFT  = 2'd1;
    localparam logic [1:0] M_RIGHT = 2'd2;

    localparam int P = ffaa_pkg::POS_W;
    localparam int C = ffaa_pkg::CNT_W;
    localparam int A = ffaa_pkg::ALIGN_W;
    localparam int T = ffaa_pkg::TOT_W;

    logic [1:0]                    r_state;
    logic                          r_op;
    logic [P-1:0]                  r_size;
    logic [A-1:0]                  r_align;
    logic [ffaa_pkg::ADDR_W-1:0]   r_addr;
    logic [ffaa_pkg::ADDR_W-1:0]   r_pool_base;
    logic [C-1:0]                  r_ext_cnt, n_ext_cnt;
    logic [P-1:0]                  r_used;
    logic [C-1:0]                  r_live;
    logic [ffaa_pkg::MAX_RECORDS-1:0] r_valid;
    logic [C-1:0]                  r_step;
    logic [C-1:0]                  r_scan;
    logic                          r_rd_vld;
    logic [ffaa_pkg::RIDX_W-1:0]   r_rd_idx;
    logic [ffaa_pkg::RIDX_W-1:0]   r_k;
    logic [ffaa_pkg::RIDX_W-1:0]   r_slot;
    logic                          r_slot_found;
    ffaa_pkg::t_ext                r_hold, n_hold, r_hold2, n_hold2;
    logic [1:0]                    r_mode, n_mode;
    logic                          r_done, n_done;
    logic [ffaa_pkg::STAT_W-1:0]   r_status, n_status;
    ffaa_pkg::t_rec                r_rec, n_rec;

    logic                          r_out_valid;
    logic [ffaa_pkg::STAT_W-1:0]   r_o_status;
    logic [ffaa_pkg::ADDR_W-1:0]   r_o_grant;
    logic [P-1:0]                  r_o_used;
    logic [C-1:0]                  r_o_live;

    ffaa_pkg::t_ext                w_head, w_feed, w_load_val;
    ffaa_pkg::t_chain_ctl          w_ctl;
    ffaa_pkg::t_rec                w_rd;
    logic                          w_pool_wr, w_accept, w_out_free, w_commit;
    logic [P-1:0]                  w_sat;

    logic                          w_vk;
    logic [A-1:0]                  w_lo, w_r, w_off;
    logic [T-1:0]                  w_total, w_rem;
    logic                          w_fits, w_consume;
    logic                          w_hit, w_prev, w_next;
    logic                          w_match;
    logic [ffaa_pkg::ADDR_W-1:0]   w_raddr_abs;

    assign w_pool_wr = i_cfg_wr_en && (i_cfg_index == ffaa_pkg::CFG_POOL_BYTES);
    assign w_sat     = (i_cfg_data[P-1:0] > P'(ffaa_pkg::POOL_MAX))
                     ? P'(ffaa_pkg::POOL_MAX) : i_cfg_data[P-1:0];
    assign w_load_val = '{start: '0, len: (!i_rst_n) ? P'(ffaa_pkg::POOL_MAX) : w_sat};
    assign w_ctl.load  = !i_rst_n || w_pool_wr;
    assign w_ctl.shift = (r_state == S_PASS);

    ffaa_ext_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_load_val (w_load_val),
        .i_feed     (w_feed),
        .o_head     (w_head)
    );

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_commit   = (r_state == S_DONE) && w_out_free;

    ffaa_rec_mem u_rec (
        .i_clk   (i_clk),
        .i_we    (w_commit && (r_status == ffaa_pkg::ST_OK) && (r_op == ffaa_pkg::OP_ALLOC)),
        .i_waddr (r_slot),
        .i_wdata (r_rec),
        .i_raddr (r_scan[ffaa_pkg::RIDX_W-1:0]),
        .o_rdata (w_rd)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);

    // record lookup compare
    assign w_raddr_abs = r_pool_base + {{(ffaa_pkg::ADDR_W-P){1'b0}}, w_rd.start}
                       + {{(ffaa_pkg::ADDR_W-A){1'b0}}, w_rd.offset};
    assign w_match     = r_valid[r_rd_idx] && (w_raddr_abs == r_addr);

    // fit test on the extent at the head
    always_comb begin
        w_vk      = (r_step < r_ext_cnt);
        w_lo      = r_pool_base[A-1:0] + w_head.start[A-1:0] + A'(ffaa_pkg::HEADER_BYTES);
        w_r       = w_lo & (r_align - A'(1));
        w_off     = A'(ffaa_pkg::HEADER_BYTES) + ((w_r != '0) ? (r_align - w_r) : '0);
        w_total   = T'(r_size) + T'(w_off);
        w_fits    = T'(w_head.len) > w_total;
        w_rem     = T'(w_head.len) - w_total;
        w_consume = w_rem <= T'(ffaa_pkg::MIN_BLOCK_BYTES);
        w_hit     = (w_vk && (w_head.start > r_rec.start)) || (r_step == r_ext_cnt);
        w_prev    = (r_step != '0)
                 && ((T'(r_hold.start) + T'(r_hold.len)) == T'(r_rec.start));
        w_next    = w_vk && (T'(w_head.start) == (T'(r_rec.start) + T'(r_rec.total)));
    end

    always_comb begin
        n_hold    = r_hold;
        n_hold2   = r_hold2;
        w_feed    = r_hold;
        n_mode    = r_mode;
        n_done    = r_done;
        n_status  = r_status;
        n_ext_cnt = r_ext_cnt;
        n_rec     = r_rec;
        unique case (r_mode)
            M_NORM: begin
                n_hold = w_head;
            end
            M_LEFT: begin
                w_feed = w_head;
            end
            M_RIGHT: begin
                n_hold  = r_hold2;
                n_hold2 = w_head;
            end
            default: begin
                n_hold = w_head;
            end
        endcase
        if ((r_state == S_PASS) && !r_done) begin
            if (r_op == ffaa_pkg::OP_ALLOC) begin
                if (w_vk && w_fits) begin
                    n_done       = 1'b1;
                    n_status     = ffaa_pkg::ST_OK;
                    n_rec.start  = w_head.start;
                    n_rec.offset = w_off;
                    if (w_consume) begin
                        n_rec.total = w_head.len;
                        n_mode      = M_LEFT;
                        n_ext_cnt   = r_ext_cnt - C'(1);
                    end else begin
                        n_rec.total = w_total[P-1:0];
                        n_hold      = '{start: w_head.start + w_total[P-1:0],
                                        len:   w_head.len - w_total[P-1:0]};
                    end
                end
            end else if (w_hit) begin
                n_done   = 1'b1;
                n_status = ffaa_pkg::ST_OK;
                if (w_prev && w_next) begin
                    w_feed    = '{start: r_hold.start,
                                  len:   r_hold.len + r_rec.total + w_head.len};
                    n_mode    = M_LEFT;
                    n_ext_cnt = r_ext_cnt - C'(1);
                end else if (w_prev) begin
                    w_feed = '{start: r_hold.start, len: r_hold.len + r_rec.total};
                end else if (w_next) begin
                    n_hold = '{start: r_rec.start, len: w_head.len + r_rec.total};
                end else if (r_ext_cnt >= C'(ffaa_pkg::MAX_EXTENTS)) begin
                    n_status = ffaa_pkg::ST_FULL;
                end else begin
                    n_hold    = '{start: r_rec.start, len: r_rec.total};
                    n_hold2   = w_head;
                    n_mode    = M_RIGHT;
                    n_ext_cnt = r_ext_cnt + C'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_base  <= ffaa_pkg::ADDR_W'(65536);
            r_ext_cnt    <= C'(1);
            r_used       <= '0;
            r_live       <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_done       <= 1'b0;
            r_mode       <= M_NORM;
            r_slot_found <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en && (i_cfg_index == ffaa_pkg::CFG_POOL_BASE)) begin
                r_pool_base <= i_cfg_data;
            end
            if (w_pool_wr) begin
                r_ext_cnt <= C'(1);
                r_used    <= '0;
                r_live    <= '0;
                r_valid   <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= i_req.opcode;
                        r_size       <= i_req.request_bytes;
                        r_align      <= ffaa_pkg::norm_align(i_req.align_bytes);
                        r_addr       <= i_req.free_address;
                        r_step       <= '0;
                        r_scan       <= '0;
                        r_rd_vld     <= 1'b0;
                        r_slot       <= '0;
                        r_slot_found <= 1'b0;
                        r_done       <= 1'b0;
                        r_mode       <= M_NORM;
                        r_status     <= ffaa_pkg::ST_NOFIT;
                        if (i_req.opcode == ffaa_pkg::OP_ALLOC) begin
                            if (r_live == C'(ffaa_pkg::MAX_RECORDS)) begin
                                r_status <= ffaa_pkg::ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_PASS;
                            end
                        end else if (i_req.free_address == '0) begin
                            r_status <= ffaa_pkg::ST_NULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_RSCAN;
                        end
                    end
                end
                S_RSCAN: begin
                    if (r_scan < C'(ffaa_pkg::MAX_RECORDS)) begin
                        r_scan <= r_scan + C'(1);
                    end
                    r_rd_vld <= (r_scan < C'(ffaa_pkg::MAX_RECORDS));
                    r_rd_idx <= r_scan[ffaa_pkg::RIDX_W-1:0];
                    if (r_rd_vld) begin
                        if (w_match) begin
                            r_rec   <= w_rd;
                            r_k     <= r_rd_idx;
                            r_state <= S_PASS;
                        end else if (r_rd_idx == ffaa_pkg::RIDX_W'(ffaa_pkg::MAX_RECORDS - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PASS: begin
                    r_hold    <= n_hold;
                    r_hold2   <= n_hold2;
                    r_mode    <= n_mode;
                    r_done    <= n_done;
                    r_status  <= n_status;
                    r_ext_cnt <= n_ext_cnt;
                    r_rec     <= n_rec;
                    if ((r_op == ffaa_pkg::OP_ALLOC) && !r_slot_found) begin
                        if (!r_valid[r_slot]) begin
                            r_slot_found <= 1'b1;
                        end else begin
                            r_slot <= r_slot + ffaa_pkg::RIDX_W'(1);
                        end
                    end
                    if (r_step == C'(ffaa_pkg::MAX_EXTENTS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + C'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_grant   <= '0;
                        r_o_used    <= r_used;
                        r_o_live    <= r_live;
                        if (r_status == ffaa_pkg::ST_OK) begin
                            if (r_op == ffaa_pkg::OP_ALLOC) begin
                                r_valid[r_slot] <= 1'b1;
                                r_used          <= r_used + r_rec.total;
                                r_live          <= r_live + C'(1);
                                r_o_used        <= r_used + r_rec.total;
                                r_o_live        <= r_live + C'(1);
                                r_o_grant       <= r_pool_base
                                    + {{(ffaa_pkg::ADDR_W-P){1'b0}}, r_rec.start}
                                    + {{(ffaa_pkg::ADDR_W-A){1'b0}}, r_rec.offset};
                            end else begin
                                r_valid[r_k] <= 1'b0;
                                r_used       <= r_used - r_rec.total;
                                r_live       <= r_live - C'(1);
                                r_o_used     <= r_used - r_rec.total;
                                r_o_live     <= r_live - C'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.granted_address = r_o_grant;
    assign o_rsp.used_total      = r_o_used;
    assign o_rsp.live_count      = r_o_live;
endmodule

>>> rtl/ffaa_chk.sv
// port checker of the allocator and its bind
module ffaa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [ffaa_pkg::STAT_W-1:0]   i_status,
    input logic [ffaa_pkg::ADDR_W-1:0]   i_granted,
    input logic [ffaa_pkg::POS_W-1:0]    i_used,
    input logic [ffaa_pkg::CNT_W-1:0]    i_live
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_granted))
        else $error("response beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one in flight");

    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != ffaa_pkg::ST_OK) |-> i_granted == '0)
        else $error("address granted on failed request");

    a_used_vs_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_live == '0) == (i_used == '0))
            && (i_live <= ffaa_pkg::CNT_W'(ffaa_pkg::MAX_RECORDS)))
        else $error("used bytes inconsistent with live count");
endmodule

bind first_fit_aligned_allocator_unit ffaa_chk u_ffaa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_granted   (o_rsp.granted_address),
    .i_used      (o_rsp.used_total),
    .i_live      (o_rsp.live_count)
);
